// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/mcc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcc_pkg
// types, constants and the byte step of the multi-context crc-32
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcc_pkg;

    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned INDEX_W  = 4;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CRC_W    = 32;

    localparam logic [CRC_W-1:0]  POLY_REFLECTED = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0]  ALL_ONES       = 32'hFFFF_FFFF;
    localparam logic [BYTE_W-1:0] BYTE_MASK      = 8'hFF;

    typedef enum logic [OPCODE_W-1:0] {
        OP_START  = 2'd0,
        OP_FOLD   = 2'd1,
        OP_FINISH = 2'd2
    } t_opcode;

    typedef struct packed {
        logic                fire;
        logic [OPCODE_W-1:0] opcode;
        logic [INDEX_W-1:0]  context_index;
        logic [BYTE_W-1:0]   data_byte;
    } t_ctx_req;

    typedef struct packed {
        logic [CRC_W-1:0] crc_value;
        logic             context_was_active;
    } t_ctx_rsp;

    // one reflected byte step, eight bit shifts
    function automatic logic [CRC_W-1:0] crc_fold_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] r;
        r = {{(CRC_W-BYTE_W){1'b0}}, (crc[BYTE_W-1:0] ^ data) & BYTE_MASK};
        for (int b = 0; b < BYTE_W; b++) begin
            r = r[0] ? ((r >> 1) ^ POLY_REFLECTED) : (r >> 1);
        end
        return r ^ (crc >> BYTE_W);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mcc_ctx_bank.sv =====
// ----------------------------------------------------------------------------
// mcc_ctx_bank
// bank of crc contexts with the per-item read, update and write back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mcc_ctx_bank #(
    parameter int unsigned DEPTH = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mcc_pkg::t_ctx_req   i_req,
    output mcc_pkg::t_ctx_rsp   o_rsp
);
    import mcc_pkg::*;

    localparam int unsigned       IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [INDEX_W:0]  DEPTH_L = (INDEX_W+1)'(DEPTH);

    logic [CRC_W-1:0] r_ctx [DEPTH];

    logic             in_range;
    logic [IDX_W-1:0] ctx_idx;
    logic [CRC_W-1:0] cur;
    logic             active;
    logic [CRC_W-1:0] n_ctx;
    logic [CRC_W-1:0] crc_out;

    assign in_range = ({1'b0, i_req.context_index} < DEPTH_L);
    assign ctx_idx  = in_range ? i_req.context_index[IDX_W-1:0] : '0;
    assign cur      = in_range ? r_ctx[ctx_idx] : '0;
    assign active   = (cur != '0);

    always_comb begin
        n_ctx   = cur;
        crc_out = '0;
        case (i_req.opcode)
            OP_START: begin
                n_ctx = ALL_ONES;
            end
            OP_FOLD: begin
                if (active) begin
                    n_ctx = crc_fold_byte(cur, i_req.data_byte);
                end
            end
            OP_FINISH: begin
                if (active) begin
                    crc_out = cur ^ ALL_ONES;
                    n_ctx   = '0;
                end
            end
            default: begin
                n_ctx = cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_ctx[k] <= '0;
            end
        end else if (i_req.fire && in_range) begin
            r_ctx[ctx_idx] <= n_ctx;
        end
    end

    assign o_rsp.crc_value          = crc_out;
    assign o_rsp.context_was_active = active;

    `ASSERT_CLK(a_start_loads_ones,
        (i_req.fire && in_range && i_req.opcode == OP_START)
            |=> (r_ctx[$past(ctx_idx)] == ALL_ONES),
        "start did not load all ones")
    `ASSERT_CLK(a_result_needs_active,
        (o_rsp.crc_value != '0) |-> o_rsp.context_was_active,
        "nonzero crc from an inactive context")

endmodule

`default_nettype wire

// ===== rtl/multi_context_crc32.sv =====
// ----------------------------------------------------------------------------
// multi_context_crc32
// crc-32 (reflected 0xedb88320) engine holding a bank of independent contexts
// ----------------------------------------------------------------------------
// usage
//   input channel i_valid / o_ready carries opcode, context index and data
//   byte; output channel o_valid / i_ready carries crc value and the
//   context-was-active flag, exactly one output beat per input beat
//   opcodes: start loads all ones, fold runs one byte step, finish returns
//   the inverted crc and frees the context; a zero context is inactive
//   an accepted beat passes two registers on its way to the output: input
//   stage, then result stage
//   throughput: one beat per cycle unless stalled, set by the single byte
//   step that sits between the input register and the context bank write back
//   back-to-back beats to the same context chain through the bank
//   reset clears every context to inactive and empties both stages
//   when the receiver stalls, the result stage holds and o_ready drops once
//   the input stage is full as well; no beat is lost or repeated
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module multi_context_crc32 #(
    parameter int unsigned CONTEXTS = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  [mcc_pkg::OPCODE_W-1:0]  i_opcode,
    input  wire  [mcc_pkg::INDEX_W-1:0]   i_context_index,
    input  wire  [mcc_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic [mcc_pkg::CRC_W-1:0]     o_crc_value,
    output logic                          o_context_was_active
);
    import mcc_pkg::*;

    // only the contexts the index port can reach are stored
    localparam int unsigned BANK_DEPTH =
        (CONTEXTS < (1 << INDEX_W)) ? CONTEXTS : (1 << INDEX_W);

    logic                r_in_vld;
    logic [OPCODE_W-1:0] r_opcode;
    logic [INDEX_W-1:0]  r_index;
    logic [BYTE_W-1:0]   r_data;

    logic                r_out_vld;
    logic [CRC_W-1:0]    r_crc;
    logic                r_active;

    logic     advance;
    t_ctx_req bank_req;
    t_ctx_rsp bank_rsp;

    assign advance = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || advance;

    assign bank_req.fire          = advance;
    assign bank_req.opcode        = r_opcode;
    assign bank_req.context_index = r_index;
    assign bank_req.data_byte     = r_data;

    mcc_ctx_bank #(
        .DEPTH (BANK_DEPTH)
    ) u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (bank_req),
        .o_rsp   (bank_rsp)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_opcode <= i_opcode;
            r_index  <= i_context_index;
            r_data   <= i_data_byte;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_crc    <= bank_rsp.crc_value;
            r_active <= bank_rsp.context_was_active;
        end
    end

    assign o_valid              = r_out_vld;
    assign o_crc_value          = r_crc;
    assign o_context_was_active = r_active;

    `ASSERT_ALWAYS(a_reset_empties,
        !i_rst_n |=> (!r_in_vld && !r_out_vld),
        "pipeline not empty after reset")
    `ASSERT_CLK(a_stalled_input_holds,
        (r_in_vld && !advance) |=> (r_in_vld && $stable(r_index) && $stable(r_opcode)),
        "input stage lost a stalled beat")
    `ASSERT_CLK(a_out_crc_needs_active,
        (o_valid && o_crc_value != '0) |-> o_context_was_active,
        "nonzero crc beat from an inactive context")

endmodule

`default_nettype wire
